@@ src/rrm_pkg.sv @@
// Shared types and constants of the row rectangle run merger.
// Used by the interfaces, the front, back and output queue modules and the top level.
`default_nettype none

package rrm_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // queue depths, powers of two
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    // shape kinds; code 3 is folded to KIND_OTHER at the front
    typedef enum logic [1:0] {
        KIND_SQUARE = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_OTHER  = 2'd2
    } t_kind;

    // back to output queue: words written this cycle, word 0 first
    typedef struct packed {
        logic push0;
        logic push1;
    } t_oq_push;

    // output queue to back
    typedef struct packed {
        logic room2;
    } t_oq_stat;

endpackage

`default_nettype wire

@@ src/rrm_shape_if.sv @@
// Valid/ready channel interfaces for shape words entering and leaving the merger.
// Depends on rrm_pkg for the default coordinate width.
`default_nettype none

interface rrm_shape_in_if
    import rrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  last_in;

    modport source (
        output valid, kind, start_x, start_y, width, height, end_x, end_y,
               red, green, blue, last_in,
        input  ready
    );
    modport sink (
        input  valid, kind, start_x, start_y, width, height, end_x, end_y,
               red, green, blue, last_in,
        output ready
    );
endinterface

interface rrm_shape_out_if
    import rrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            out_kind;
    logic [COORD_BITS-1:0] out_start_x;
    logic [COORD_BITS-1:0] out_start_y;
    logic [COORD_BITS-1:0] out_width;
    logic [COORD_BITS-1:0] out_height;
    logic [COORD_BITS-1:0] out_end_x;
    logic [COORD_BITS-1:0] out_end_y;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  out_last;

    modport source (
        output valid, out_kind, out_start_x, out_start_y, out_width, out_height,
               out_end_x, out_end_y, out_red, out_green, out_blue, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_start_x, out_start_y, out_width, out_height,
               out_end_x, out_end_y, out_red, out_green, out_blue, out_last,
        output ready
    );
endinterface

`default_nettype wire

@@ src/rrm_front.sv @@
// Front of the merger: accepts shape words, folds the kind, precomputes the
// saturated far corner and buffers classified words. Depends on rrm_pkg, rrm_shape_in_if.
`default_nettype none

module rrm_front
    import rrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    rrm_shape_in_if.sink          i_shape,
    output logic                  o_item_valid,
    output logic [8*COORD_BITS+26:0] o_item,
    input  wire logic             i_item_ready
);
    localparam int C      = COORD_BITS;
    localparam int ITEM_W = 8 * C + 27;
    localparam int PW     = $clog2(IQ_DEPTH);
    localparam int CW     = $clog2(IQ_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(IQ_DEPTH);

    logic [ITEM_W-1:0] r_mem [IQ_DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count,  n_count;

    t_kind             cls_kind;
    logic [C:0]        sum_x, sum_y;
    logic [C-1:0]      sq_end_x, sq_end_y;
    logic [ITEM_W-1:0] cls_item;
    logic              in_fire, out_fire;

    always_comb begin
        case (i_shape.kind)
            KIND_SQUARE: cls_kind = KIND_SQUARE;
            KIND_LINE:   cls_kind = KIND_LINE;
            default:     cls_kind = KIND_OTHER;
        endcase
    end

    // saturated right and bottom edge of the word seen as a square
    assign sum_x    = {1'b0, i_shape.start_x} + {1'b0, i_shape.width};
    assign sum_y    = {1'b0, i_shape.start_y} + {1'b0, i_shape.height};
    assign sq_end_x = sum_x[C] ? {C{1'b1}} : sum_x[C-1:0];
    assign sq_end_y = sum_y[C] ? {C{1'b1}} : sum_y[C-1:0];

    assign cls_item = {cls_kind, i_shape.start_x, i_shape.start_y, i_shape.width,
                       i_shape.height, i_shape.end_x, i_shape.end_y, sq_end_x, sq_end_y,
                       i_shape.blue, i_shape.green, i_shape.red, i_shape.last_in};

    assign i_shape.ready = (r_count != FULL);
    assign in_fire       = i_shape.valid && i_shape.ready;
    assign o_item_valid  = (r_count != '0);
    assign out_fire      = o_item_valid && i_item_ready;
    assign o_item        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(in_fire);
        n_rd_ptr = r_rd_ptr + PW'(out_fire);
        n_count  = r_count + CW'(in_fire) - CW'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

endmodule

`default_nettype wire

@@ src/rrm_back.sv @@
// Back of the merger: holds the pending shape, absorbs abutting squares and
// writes up to two result words per item. Depends on rrm_pkg.
`default_nettype none

module rrm_back
    import rrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_item_valid,
    input  wire logic [8*COORD_BITS+26:0]   i_item,
    output logic                            o_item_ready,
    input  wire t_oq_stat                   i_oq_stat,
    output t_oq_push                        o_oq_push,
    output logic [6*COORD_BITS+26:0]        o_oq_data0,
    output logic [6*COORD_BITS+26:0]        o_oq_data1
);
    localparam int C     = COORD_BITS;
    localparam int OUT_W = 6 * C + 27;

    logic [1:0]   it_kind_raw;
    t_kind        it_kind;
    logic [C-1:0] it_sx, it_sy, it_w, it_h, it_ex, it_ey, it_sqx, it_sqy;
    logic [23:0]  it_col;
    logic         it_last;

    logic         r_held_valid;
    t_kind        r_kind,  n_kind;
    logic [C-1:0] r_sx, r_sy, r_w, r_h, r_ex, r_ey, r_sqx, r_sqy;
    logic [C-1:0] n_sx, n_sy, n_w, n_h, n_ex, n_ey, n_sqx, n_sqy;
    logic [23:0]  r_col, n_col;

    logic         item_fire, merge, emit_old, emit_flush;
    logic [C-1:0] held_end_col, held_rows;
    logic [OUT_W-1:0] old_word, flush_word;

    assign {it_kind_raw, it_sx, it_sy, it_w, it_h, it_ex, it_ey, it_sqx, it_sqy,
            it_col, it_last} = i_item;
    assign it_kind = t_kind'(it_kind_raw);

    assign o_item_ready = i_oq_stat.room2;
    assign item_fire    = i_item_valid && o_item_ready;

    // a square ends at its precomputed corner, a line at its stored end
    assign held_end_col = (r_kind == KIND_SQUARE) ? r_sqx : r_ex;
    assign held_rows    = (r_kind == KIND_SQUARE) ? r_h : r_w;

    assign merge = r_held_valid && (it_kind == KIND_SQUARE)
                && ((r_kind == KIND_SQUARE) || (r_kind == KIND_LINE))
                && (r_col == it_col) && (r_sy == it_sy)
                && (held_rows == it_h) && (held_end_col == it_sx);

    always_comb begin
        n_kind = r_kind;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_w    = r_w;
        n_h    = r_h;
        n_ex   = r_ex;
        n_ey   = r_ey;
        n_sqx  = r_sqx;
        n_sqy  = r_sqy;
        n_col  = r_col;
        if (merge) begin
            if (r_kind == KIND_SQUARE) begin
                n_kind = KIND_LINE;
                n_ey   = r_sqy;
                n_w    = r_h;
            end
            n_ex = it_sqx;
        end else begin
            n_kind = it_kind;
            n_sx   = it_sx;
            n_sy   = it_sy;
            n_w    = it_w;
            n_h    = it_h;
            n_ex   = it_ex;
            n_ey   = it_ey;
            n_sqx  = it_sqx;
            n_sqy  = it_sqy;
            n_col  = it_col;
        end
    end

    assign old_word   = {r_kind, r_sx, r_sy, r_w, r_h, r_ex, r_ey,
                         r_col[7:0], r_col[15:8], r_col[23:16], 1'b0};
    assign flush_word = {n_kind, n_sx, n_sy, n_w, n_h, n_ex, n_ey,
                         n_col[7:0], n_col[15:8], n_col[23:16], 1'b1};

    assign emit_old   = item_fire && r_held_valid && !merge;
    assign emit_flush = item_fire && it_last;

    always_comb begin
        o_oq_push.push0 = emit_old || emit_flush;
        o_oq_push.push1 = emit_old && emit_flush;
        o_oq_data0      = emit_old ? old_word : flush_word;
        o_oq_data1      = flush_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (item_fire) begin
            r_held_valid <= !it_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_fire) begin
            r_kind <= n_kind;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_w    <= n_w;
            r_h    <= n_h;
            r_ex   <= n_ex;
            r_ey   <= n_ey;
            r_sqx  <= n_sqx;
            r_sqy  <= n_sqy;
            r_col  <= n_col;
        end
    end

    a_push_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_oq_push.push0 |-> (item_fire && i_oq_stat.room2))
        else $error("result word written without an accepted item");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_fire && it_last) |=> !r_held_valid)
        else $error("pending shape still held after flush");

    a_merge_is_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_fire && merge && !it_last) |=> (r_held_valid && (r_kind == KIND_LINE)))
        else $error("merged shape is not a pending line");

    a_merge_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_fire && merge && !it_last) |-> !o_oq_push.push0)
        else $error("merge emitted a word");

endmodule

`default_nettype wire

@@ src/rrm_out_queue.sv @@
// Output queue of result words: up to two writes and one read per cycle.
// Depends on rrm_pkg for the push/status structs and depth.
`default_nettype none

module rrm_out_queue
    import rrm_pkg::*;
#(
    parameter int WIDTH = 6 * COORD_BITS_DEF + 27
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_oq_push         i_push,
    input  wire logic [WIDTH-1:0] i_data0,
    input  wire logic [WIDTH-1:0] i_data1,
    output t_oq_stat              o_stat,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_ready
);
    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);
    localparam logic [CW-1:0] ROOM2_MAX = CW'(OQ_DEPTH - 2);

    logic [WIDTH-1:0] r_mem [OQ_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             pop;

    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign pop          = o_valid && i_ready;
    assign o_stat.room2 = (r_count <= ROOM2_MAX);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.push0) + PW'(i_push.push1);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_count  = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + PW'(1)] <= i_data1;
        end
    end

endmodule

`default_nettype wire

@@ src/row_rectangle_run_merger_top.sv @@
// Top level of the row rectangle run merger: front, back and output queue.
// Depends on rrm_pkg, rrm_shape_if, rrm_front, rrm_back, rrm_out_queue.
//
// Usage:
//   i_shape carries shape words (square, horizontal line, other) in valid/ready
//   form; a word is taken on a rising edge with valid and ready high. o_shape
//   carries result words the same way. One shape is held pending; an abutting
//   square of equal colour, row and height is absorbed into a pending square or
//   line, else the pending shape leaves. last_in flushes it (out_last = 1).
//   Path: the front queue registers the word, the back is combinational and
//   the output queue registers the result word.
//   Throughput: one input word and one result word per cycle unless stalled;
//   the back handles one word per cycle while the output queue has room for
//   two.
//   Reset (synchronous, i_rst_n low): both queues empty, nothing pending.
//   Receiver stall: the four-word output queue absorbs results; when fewer
//   than two slots are free the back holds, the two-word front queue fills,
//   and then i_shape.ready drops. No word is lost or repeated.
`default_nettype none

module row_rectangle_run_merger_top
    import rrm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rrm_shape_in_if.sink    i_shape,
    rrm_shape_out_if.source o_shape
);
    localparam int ITEM_W = 8 * COORD_BITS + 27;
    localparam int OUT_W  = 6 * COORD_BITS + 27;

    // front to back: classified words
    logic              item_valid;
    logic              item_ready;
    logic [ITEM_W-1:0] item;

    // back to output queue
    t_oq_push          oq_push;
    t_oq_stat          oq_stat;
    logic [OUT_W-1:0]  oq_data0;
    logic [OUT_W-1:0]  oq_data1;
    logic [OUT_W-1:0]  head;

    rrm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_shape      (i_shape),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    rrm_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .i_oq_stat    (oq_stat),
        .o_oq_push    (oq_push),
        .o_oq_data0   (oq_data0),
        .o_oq_data1   (oq_data1)
    );

    rrm_out_queue #(
        .WIDTH (OUT_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data0 (oq_data0),
        .i_data1 (oq_data1),
        .o_stat  (oq_stat),
        .o_valid (o_shape.valid),
        .o_data  (head),
        .i_ready (o_shape.ready)
    );

    // head word layout matches the back's packing
    assign {o_shape.out_kind, o_shape.out_start_x, o_shape.out_start_y,
            o_shape.out_width, o_shape.out_height, o_shape.out_end_x,
            o_shape.out_end_y, o_shape.out_red, o_shape.out_green,
            o_shape.out_blue, o_shape.out_last} = head;

endmodule

`default_nettype wire

@@ test/row_rectangle_run_merger_top_tb.sv @@
// Self-checking testbench for row_rectangle_run_merger_top: directed shape lists, then random runs.
// Depends on rrm_pkg, rrm_shape_if and the merger RTL; holds its own model of the pending shape.
`timescale 1ns / 100ps

module row_rectangle_run_merger_top_tb
    import rrm_pkg::*;
;

    localparam int CW            = COORD_BITS_DEF;
    localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};
    localparam logic [1:0] KIND_CODE_SPARE = 2'd3;   // folded to other by the block
    localparam int N_FIELDS      = 11;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 40;

    // one shape word, used for both directions
    typedef struct {
        logic [1:0]    kind;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic          last;
    } t_shape;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_LIGHT,   // ready at random, with a chance of three in four
        RX_HEAVY,   // ready at random, with a chance of one in four
        RX_LONG     // long stretches on and off
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrm_shape_in_if  #(.COORD_BITS(CW)) shape_in ();
    rrm_shape_out_if #(.COORD_BITS(CW)) shape_out ();

    row_rectangle_run_merger_top #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shape (shape_in),
        .o_shape (shape_out)
    );

    always #5 i_clk = ~i_clk;

    // model of the pending shape and the words it is owed
    t_shape held_shape;
    bit     held_valid = 1'b0;
    t_shape expected_shapes [$];

    int items_sent     = 0;
    int words_received = 0;
    int error_count    = 0;
    int merge_count    = 0;
    int flush_count    = 0;
    int sat_end_count  = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    t_stall_mode rx_mode      = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_run_left  = 0;
    logic        rx_hold      = 1'b1;

    string field_names [N_FIELDS] = '{"out_kind", "out_start_x", "out_start_y", "out_width",
                                      "out_height", "out_end_x", "out_end_y", "out_red",
                                      "out_green", "out_blue", "out_last"};

    function automatic logic [CW-1:0] sat_sum(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? COORD_MAX : s[CW-1:0];
    endfunction

    // Pending-shape model. One accepted word in, zero to two expected words queued.
    function automatic void predict_run_merge(t_shape s);
        t_kind         kind;
        logic [CW-1:0] rows;
        logic [CW-1:0] end_col;
        logic          absorb;
        kind = (s.kind == KIND_CODE_SPARE) ? KIND_OTHER : t_kind'(s.kind);
        // a held square measures rows by height, a held line by its width field
        rows    = (held_shape.kind == KIND_SQUARE) ? held_shape.h : held_shape.w;
        end_col = (held_shape.kind == KIND_SQUARE) ? sat_sum(held_shape.sx, held_shape.w)
                                                   : held_shape.ex;
        absorb = held_valid && kind == KIND_SQUARE && held_shape.kind != KIND_OTHER
              && held_shape.red == s.red && held_shape.green == s.green
              && held_shape.blue == s.blue && held_shape.sy == s.sy
              && rows == s.h && end_col == s.sx;
        if (absorb) begin
            if (held_shape.kind == KIND_SQUARE) begin
                // square turns into a line spanning its own extent first
                held_shape.kind = KIND_LINE;
                held_shape.ey   = sat_sum(held_shape.sy, held_shape.h);
                held_shape.w    = held_shape.h;
            end
            held_shape.ex = sat_sum(s.sx, s.w);
            merge_count++;
            if (held_shape.ex == COORD_MAX)
                sat_end_count++;
        end else begin
            if (held_valid)
                expected_shapes = {expected_shapes, held_shape};
            held_shape      = s;
            held_shape.kind = kind;
            held_shape.last = 1'b0;
            held_valid      = 1'b1;
        end
        if (s.last) begin
            held_shape.last = 1'b1;
            expected_shapes = {expected_shapes, held_shape};
            held_valid = 1'b0;
            flush_count++;
        end
    endfunction

    function automatic logic [31:0] shape_field(t_shape s, int f);
        case (f)
            0:       return 32'(s.kind);
            1:       return 32'(s.sx);
            2:       return 32'(s.sy);
            3:       return 32'(s.w);
            4:       return 32'(s.h);
            5:       return 32'(s.ex);
            6:       return 32'(s.ey);
            7:       return 32'(s.red);
            8:       return 32'(s.green);
            9:       return 32'(s.blue);
            default: return 32'(s.last);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        // keep the log short if the block is badly broken
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH word %0d %s: got 0x%0h, expected 0x%0h",
                     words_received, what, got, want);
    endtask

    // Sender: bursts of random length, random gaps between them. valid stays high
    // across back-to-back words and drops only when a gap starts.
    task automatic send_shape(t_shape s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                shape_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        shape_in.valid   <= 1'b1;
        shape_in.kind    <= s.kind;
        shape_in.start_x <= s.sx;
        shape_in.start_y <= s.sy;
        shape_in.width   <= s.w;
        shape_in.height  <= s.h;
        shape_in.end_x   <= s.ex;
        shape_in.end_y   <= s.ey;
        shape_in.red     <= s.red;
        shape_in.green   <= s.green;
        shape_in.blue    <= s.blue;
        shape_in.last_in <= s.last;
        do @(posedge i_clk); while (shape_in.ready !== 1'b1);
        predict_run_merge(s);
        items_sent++;
    endtask

    function automatic t_shape make_shape(logic [1:0] kind, logic [CW-1:0] sx,
                                          logic [CW-1:0] sy,
                                          logic [CW-1:0] w, logic [CW-1:0] h,
                                          logic [CW-1:0] ex, logic [CW-1:0] ey,
                                          logic [23:0] rgb, logic last);
        t_shape s;
        s.kind  = kind;
        s.sx    = sx;
        s.sy    = sy;
        s.w     = w;
        s.h     = h;
        s.ex    = ex;
        s.ey    = ey;
        s.red   = rgb[23:16];
        s.green = rgb[15:8];
        s.blue  = rgb[7:0];
        s.last  = last;
        return s;
    endfunction

    // every bit of every field free, kind 3 included
    function automatic t_shape random_shape();
        t_shape s;
        s.kind  = 2'($urandom_range(0, 3));
        s.sx    = CW'($urandom);
        s.sy    = CW'($urandom);
        s.w     = CW'($urandom);
        s.h     = CW'($urandom);
        s.ex    = CW'($urandom);
        s.ey    = CW'($urandom);
        s.red   = 8'($urandom);
        s.green = 8'($urandom);
        s.blue  = 8'($urandom);
        s.last  = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    // mostly short extents, some zero, some anywhere in range
    function automatic logic [CW-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CW'($urandom);
            default: return CW'($urandom_range(1, 40));
        endcase
    endfunction

    // A row of abutting squares of one colour, row and height, sometimes led by a
    // line ending where the first square starts. One square may be spoiled so the
    // run breaks; the list may be closed at the end or, rarely, in the middle.
    task automatic send_run();
        t_shape        s;
        logic [CW-1:0] x;
        logic [CW-1:0] row;
        logic [CW-1:0] rows;
        logic [23:0]   rgb;
        int            len;
        int            spoil_at;
        int            flush_at;
        rgb  = 24'($urandom);
        row  = CW'($urandom);
        rows = pick_extent();
        // about one run in eight starts near the right edge to hit saturation
        x    = ($urandom_range(0, 7) == 0) ? COORD_MAX - CW'($urandom_range(0, 80))
                                           : CW'($urandom);
        len  = $urandom_range(1, 8);
        spoil_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        if ($urandom_range(0, 15) == 0)
            flush_at = $urandom_range(0, len - 1);
        else
            flush_at = ($urandom_range(0, 2) == 0) ? len - 1 : -1;
        if ($urandom_range(0, 3) == 0) begin
            s = random_shape();
            s = make_shape(KIND_LINE, s.sx, row, rows, s.h, x, s.ey, rgb, 1'b0);
            send_shape(s);
        end
        for (int i = 0; i < len; i++) begin
            s = random_shape();
            s = make_shape(KIND_SQUARE, x, row, pick_extent(), rows, s.ex, s.ey, rgb,
                           i == flush_at);
            if (i == spoil_at) begin
                case ($urandom_range(0, 4))
                    0:       s.red ^= 8'(1 << $urandom_range(0, 7));
                    1:       s.sy  += 1'b1;
                    2:       s.h   ^= CW'(1 << $urandom_range(0, CW - 1));
                    3:       s.sx  += 1'b1;
                    default: s.kind = 2'($urandom_range(1, 3));
                endcase
            end
            send_shape(s);
            x = sat_sum(x, s.w);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // all-zero and all-one fields, every kind code, a flush with nothing pending
    task automatic test_field_extremes();
        send_shape(make_shape(KIND_SQUARE, '0, '0, '0, '0, '0, '0, 24'h000000, 1'b0));
        send_shape(make_shape(KIND_SQUARE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, 24'hFFFFFF, 1'b0));
        send_shape(make_shape(KIND_OTHER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, 24'hFFFFFF, 1'b0));
        // spare kind code leaves as other
        send_shape(make_shape(KIND_CODE_SPARE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, 24'hFFFFFF, 1'b1));
        send_shape(make_shape(KIND_LINE, '0, '0, '0, '0, '0, '0, 24'h000000, 1'b1));
    endtask

    // square grows into a line; incoming lines are never absorbed but a held
    // line absorbs squares; colour, row and height breaks
    task automatic test_square_run();
        logic [23:0] c;
        c = 24'h0A141E;
        send_shape(make_shape(KIND_SQUARE, CW'(100), CW'(50), CW'(8), CW'(6), '0, '0,
                              c, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(108), CW'(50), CW'(4), CW'(6), CW'(7), CW'(7),
                              c, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(112), CW'(50), CW'(20), CW'(6), '0, '0,
                              c, 1'b0));
        send_shape(make_shape(KIND_LINE, CW'(132), CW'(50), CW'(6), '0, CW'(140), CW'(56),
                              c, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(140), CW'(50), CW'(5), CW'(6), '0, '0,
                              c, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(145), CW'(50), CW'(9), CW'(6), '0, '0,
                              c ^ 24'h1, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(154), CW'(51), CW'(3), CW'(6), '0, '0,
                              c ^ 24'h1, 1'b1));
        send_shape(make_shape(KIND_SQUARE, CW'(200), CW'(60), CW'(4), CW'(3), '0, '0,
                              c, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(204), CW'(60), CW'(4), CW'(5), '0, '0,
                              c, 1'b1));
    endtask

    // a held other shape takes nothing, even a perfectly abutting square
    task automatic test_other_never_absorbs();
        send_shape(make_shape(KIND_OTHER, '0, CW'(7), CW'(3), CW'(3), CW'(3), CW'(10),
                              24'h102030, 1'b0));
        send_shape(make_shape(KIND_SQUARE, CW'(3), CW'(7), CW'(2), CW'(3), '0, '0,
                              24'h102030, 1'b1));
    endtask

    // end column pinned at the maximum still matches a square starting there;
    // the list closes on a merging word
    task automatic test_saturated_end();
        send_shape(make_shape(KIND_SQUARE, COORD_MAX - CW'(15), CW'(9), CW'(40), CW'(2),
                              '0, '0, 24'h445566, 1'b0));
        send_shape(make_shape(KIND_SQUARE, COORD_MAX, CW'(9), CW'(1), CW'(2), '0, '0,
                              24'h445566, 1'b0));
        send_shape(make_shape(KIND_SQUARE, COORD_MAX, CW'(9), '0, CW'(2), '0, '0,
                              24'h445566, 1'b1));
    endtask

    task automatic test_random_runs();
        t_shape s;
        int     stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8)
                send_run();
            else
                send_shape(random_shape());
        end
        // close the list so nothing stays pending
        s      = random_shape();
        s.last = 1'b1;
        send_shape(s);
    endtask

    // ---------------------------------------------------------------- receiver

    // Stall pattern: holds a randomly drawn style for a random stretch, then draws anew.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shape_out.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_stall_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:  shape_out.ready <= 1'b1;
                RX_LIGHT: shape_out.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: shape_out.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (rx_run_left == 0) begin
                        rx_hold     = ~rx_hold;
                        rx_run_left = $urandom_range(1, 30);
                    end
                    rx_run_left--;
                    shape_out.ready <= rx_hold;
                end
            endcase
        end
    end

    // Every accepted result word against the oldest expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_shape want;
        t_shape got;
        if (i_rst_n && shape_out.valid === 1'b1 && shape_out.ready === 1'b1) begin
            got.kind  = shape_out.out_kind;
            got.sx    = shape_out.out_start_x;
            got.sy    = shape_out.out_start_y;
            got.w     = shape_out.out_width;
            got.h     = shape_out.out_height;
            got.ex    = shape_out.out_end_x;
            got.ey    = shape_out.out_end_y;
            got.red   = shape_out.out_red;
            got.green = shape_out.out_green;
            got.blue  = shape_out.out_blue;
            got.last  = shape_out.out_last;
            words_received++;
            if (expected_shapes.size() == 0) begin
                report_mismatch("result word with nothing expected", 0, 0);
            end else begin
                want = expected_shapes.pop_front();
                for (int f = 0; f < N_FIELDS; f++)
                    if (shape_field(got, f) !== shape_field(want, f))
                        report_mismatch(field_names[f], shape_field(got, f),
                                        shape_field(want, f));
            end
        end
    end

    // Watchdog: a hang or lost word ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_shapes.size());
            $display("row_rectangle_run_merger_top_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n           <= 1'b0;
        shape_in.valid    <= 1'b0;
        shape_in.kind     <= KIND_SQUARE;
        shape_in.start_x  <= '0;
        shape_in.start_y  <= '0;
        shape_in.width    <= '0;
        shape_in.height   <= '0;
        shape_in.end_x    <= '0;
        shape_in.end_y    <= '0;
        shape_in.red      <= '0;
        shape_in.green    <= '0;
        shape_in.blue     <= '0;
        shape_in.last_in  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_square_run();
        test_other_never_absorbs();
        test_saturated_end();
        test_random_runs();

        // last word was just taken; drop valid and let the queues drain
        shape_in.valid <= 1'b0;
        while (expected_shapes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d shape words, checked %0d result words", items_sent, words_received);
        $display("merges %0d (end pinned at max %0d), list flushes %0d, mismatches %0d",
                 merge_count, sat_end_count, flush_count, error_count);
        if (error_count == 0)
            $display("row_rectangle_run_merger_top_tb OK");
        else
            $display("row_rectangle_run_merger_top_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
src/rrm_pkg.sv
src/rrm_shape_if.sv
src/rrm_front.sv
src/rrm_back.sv
src/rrm_out_queue.sv
src/row_rectangle_run_merger_top.sv
test/row_rectangle_run_merger_top_tb.sv
